// ----- rtl/core/fss_pkg.sv -----
// ----------------------------------------------------------------------------
// fss_pkg
// Shared types, float32 constants and float32 arithmetic for the pipelined
// sine/cosine unit. Addition and multiplication round to nearest even and
// keep subnormal values; f_trunc truncates toward zero.
// ----------------------------------------------------------------------------
package fss_pkg;

  typedef struct packed {
    logic        op;
    logic [31:0] x_bits;
  } fss_in_t;

  typedef struct packed {
    logic [31:0] y_bits;
    logic        range_error;
  } fss_out_t;

  // Reduced argument handed from the reduction pipe to the polynomial pipe.
  typedef struct packed {
    logic        valid;
    logic        bad;
    logic [1:0]  k2;
    logic [31:0] r;
    logic [31:0] r2;
  } fss_red_t;

  typedef struct packed {
    logic        valid;
    logic        bad;
    logic [1:0]  k2;
    logic [31:0] s;
    logic [31:0] c;
  } fss_poly_t;

  typedef struct packed {
    logic [1:0]  k2;
    logic [31:0] kf;
  } fss_trunc_t;

  typedef enum logic [1:0] {
    QUAD_SIN     = 2'd0,
    QUAD_COS     = 2'd1,
    QUAD_NEG_SIN = 2'd2,
    QUAD_NEG_COS = 2'd3
  } fss_quad_t;

  localparam logic OP_COS = 1'b1;

  localparam logic [31:0] QNAN_BITS   = 32'h7FC0_0000;
  localparam logic [31:0] HALF_PI     = 32'h3FC9_0FDB;
  localparam logic [31:0] INV_HALF_PI = 32'h3F22_F983;
  localparam logic [31:0] CW_HI       = 32'h3FC9_0FDB;
  localparam logic [31:0] CW_LO       = 32'h248D_3132;
  localparam logic [31:0] F_ONE       = 32'h3F80_0000;
  localparam logic [31:0] F_HALF      = 32'h3F00_0000;
  localparam logic [31:0] F_NEG_HALF  = 32'hBF00_0000;
  localparam logic [31:0] SIN_C3      = 32'h3E2A_AAAB;
  localparam logic [31:0] SIN_C5      = 32'h3C08_8889;
  localparam logic [31:0] SIN_C7      = 32'h3950_0D01;
  localparam logic [31:0] COS_C4      = 32'h3D2A_AAAC;
  localparam logic [31:0] COS_C6      = 32'h3AB6_0B62;
  // Biased exponent of 2^31: a scaled argument at or above it is out of range.
  localparam logic [7:0]  EXP_2P31    = 8'd158;

  function automatic logic [31:0] f_neg(input logic [31:0] a);
    f_neg = {~a[31], a[30:0]};
  endfunction

  function automatic logic [31:0] f_add(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] x, y, res;
    logic        sx, sub, found, g, rs, rnd;
    logic [7:0]  ex, ey, d;
    logic [4:0]  dd, lz, sh;
    logic [27:0] mx, my, sum;
    logic [55:0] wide;
    logic [8:0]  e;
    logic [24:0] m;
    begin
      if (a[30:0] >= b[30:0]) begin
        x = a; y = b;
      end else begin
        x = b; y = a;
      end
      sx  = x[31];
      sub = x[31] ^ y[31];
      ex  = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
      ey  = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
      mx  = {1'b0, (x[30:23] != 8'd0), x[22:0], 3'b000};
      my  = {1'b0, (y[30:23] != 8'd0), y[22:0], 3'b000};
      d   = ex - ey;
      dd  = (d > 8'd31) ? 5'd31 : d[4:0];
      wide = {my, 28'd0} >> dd;
      my   = wide[55:28] | {27'd0, |wide[27:0]};
      sum  = sub ? (mx - my) : (mx + my);
      e    = {1'b0, ex};
      found = 1'b0;
      lz    = 5'd0;
      m     = 25'd0;
      res   = 32'd0;
      if (sum == 28'd0) begin
        res = {sx & ~sub, 31'd0};
      end else begin
        if (sum[27]) begin
          sum = {1'b0, sum[27:2], sum[1] | sum[0]};
          e   = e + 9'd1;
        end else begin
          for (int i = 26; i >= 0; i--) begin
            if (!found && sum[i]) begin
              found = 1'b1;
              lz    = 5'(26 - i);
            end
          end
          // The shift stops at the smallest exponent; the rest stays subnormal.
          if ({4'd0, lz} > (e - 9'd1)) sh = 5'(e - 9'd1);
          else sh = lz;
          sum = sum << sh;
          e   = e - {4'd0, sh};
        end
        m   = {1'b0, sum[26:3]};
        g   = sum[2];
        rs  = sum[1] | sum[0];
        rnd = g & (rs | m[0]);
        m   = m + {24'd0, rnd};
        if (m[24]) begin
          m = m >> 1;
          e = e + 9'd1;
        end
        if (e >= 9'd255) res = {sx, 8'hFF, 23'd0};
        else res = {sx, (m[23] ? e[7:0] : 8'd0), m[22:0]};
      end
      f_add = res;
    end
  endfunction

  function automatic logic [31:0] f_sub(input logic [31:0] a, input logic [31:0] b);
    f_sub = f_add(a, f_neg(b));
  endfunction

  function automatic logic [31:0] f_mul(input logic [31:0] a, input logic [31:0] b);
    logic               s, found, g, st, rnd;
    logic [7:0]         ea, eb;
    logic [23:0]        ma, mb;
    logic [47:0]        p;
    logic [5:0]         lz, rsh;
    logic signed [10:0] e, rs;
    logic [95:0]        wide;
    logic [24:0]        m;
    logic [31:0]        res;
    begin
      s     = a[31] ^ b[31];
      found = 1'b0;
      lz    = 6'd0;
      res   = 32'd0;
      if (a[30:0] == 31'd0 || b[30:0] == 31'd0) begin
        res = {s, 31'd0};
      end else begin
        ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        ma = {(a[30:23] != 8'd0), a[22:0]};
        mb = {(b[30:23] != 8'd0), b[22:0]};
        p  = ma * mb;
        for (int i = 47; i >= 0; i--) begin
          if (!found && p[i]) begin
            found = 1'b1;
            lz    = 6'(47 - i);
          end
        end
        p = p << lz;
        e = $signed({3'd0, ea}) + $signed({3'd0, eb}) - 11'sd126 - $signed({5'd0, lz});
        if (e < 11'sd1) begin
          rs   = 11'sd1 - e;
          rsh  = (rs > 11'sd63) ? 6'd63 : rs[5:0];
          wide = {p, 48'd0} >> rsh;
          p    = wide[95:48] | {47'd0, |wide[47:0]};
          e    = 11'sd1;
        end
        m   = {1'b0, p[47:24]};
        g   = p[23];
        st  = |p[22:0];
        rnd = g & (st | m[0]);
        m   = m + {24'd0, rnd};
        if (m[24]) begin
          m = m >> 1;
          e = e + 11'sd1;
        end
        if (e >= 11'sd255) res = {s, 8'hFF, 23'd0};
        else res = {s, (m[23] ? e[7:0] : 8'd0), m[22:0]};
      end
      f_mul = res;
    end
  endfunction

  // Truncates toward zero; returns the integer as a float and its two low bits.
  function automatic fss_trunc_t f_trunc(input logic [31:0] t);
    fss_trunc_t  res;
    logic [7:0]  ex;
    logic [23:0] mant;
    logic [31:0] mag;
    logic [4:0]  sh;
    begin
      ex   = t[30:23];
      mant = {1'b1, t[22:0]};
      res  = '0;
      mag  = 32'd0;
      if (ex >= 8'd127) begin
        if (ex >= 8'd150) begin
          sh     = 5'(ex - 8'd150);
          mag    = {8'd0, mant} << sh;
          res.kf = t;
        end else begin
          sh     = 5'(8'd150 - ex);
          mag    = {8'd0, mant >> sh};
          res.kf = {t[31:23], t[22:0] & (23'h7F_FFFF << sh)};
        end
        res.k2 = t[31] ? (~mag[1:0] + 2'd1) : mag[1:0];
      end
      f_trunc = res;
    end
  endfunction

endpackage

// ----- rtl/core/fss_reduce.sv -----
// ----------------------------------------------------------------------------
// fss_reduce
// Eight-stage argument reduction: cosine offset, scaling by 2/pi, quadrant
// rounding, two-step Cody-Waite reduction and the square of the result.
// ----------------------------------------------------------------------------
module fss_reduce
  import fss_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  fss_in_t  in_data,
  output fss_red_t red
);

  logic        v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, v8_r;
  logic        bad1_r, bad2_r, bad3_r, bad4_r, bad5_r, bad6_r, bad7_r, bad8_r;
  logic [31:0] xa1_r, xa2_r, xa3_r, xa4_r, xa5_r;
  logic [31:0] fk2_r, t3_r, kf4_r, p1_5_r, p2_5_r, a1_6_r, p2_6_r, r7_r, r8_r, r2_8_r;
  logic [1:0]  k2_4_r, k2_5_r, k2_6_r, k2_7_r, k2_8_r;

  logic        fin;
  logic        bad1_nxt, bad3_nxt;
  logic [31:0] xa1_nxt, fk2_nxt, t3_nxt, p1_5_nxt, p2_5_nxt, a1_6_nxt, r7_nxt, r2_8_nxt;
  fss_trunc_t  tr4_nxt;

  always_comb begin
    fin      = (in_data.x_bits[30:23] != 8'hFF);
    bad1_nxt = ~fin;
    xa1_nxt  = (in_data.op == OP_COS && fin) ? f_add(in_data.x_bits, HALF_PI)
                                              : in_data.x_bits;
    fk2_nxt  = f_mul(xa1_r, INV_HALF_PI);
    // Round half away from zero; negative zero counts as non-negative.
    t3_nxt   = (fk2_r[31] && fk2_r[30:0] != 31'd0) ? f_add(fk2_r, F_NEG_HALF)
                                                    : f_add(fk2_r, F_HALF);
    bad3_nxt = bad2_r | (fk2_r[30:23] >= EXP_2P31);
    tr4_nxt  = f_trunc(t3_r);
    p1_5_nxt = f_mul(kf4_r, CW_HI);
    p2_5_nxt = f_mul(kf4_r, CW_LO);
    a1_6_nxt = f_sub(xa5_r, p1_5_r);
    r7_nxt   = f_sub(a1_6_r, p2_6_r);
    r2_8_nxt = f_mul(r7_r, r7_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
      v5_r <= 1'b0; v6_r <= 1'b0; v7_r <= 1'b0; v8_r <= 1'b0;
    end else begin
      v1_r <= in_valid; v2_r <= v1_r; v3_r <= v2_r; v4_r <= v3_r;
      v5_r <= v4_r;     v6_r <= v5_r; v7_r <= v6_r; v8_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    bad1_r <= bad1_nxt; xa1_r <= xa1_nxt;
    bad2_r <= bad1_r;   xa2_r <= xa1_r;   fk2_r <= fk2_nxt;
    bad3_r <= bad3_nxt; xa3_r <= xa2_r;   t3_r  <= t3_nxt;
    bad4_r <= bad3_r;   xa4_r <= xa3_r;   kf4_r <= tr4_nxt.kf; k2_4_r <= tr4_nxt.k2;
    bad5_r <= bad4_r;   xa5_r <= xa4_r;   p1_5_r <= p1_5_nxt; p2_5_r <= p2_5_nxt;
    k2_5_r <= k2_4_r;
    bad6_r <= bad5_r;   a1_6_r <= a1_6_nxt; p2_6_r <= p2_5_r; k2_6_r <= k2_5_r;
    bad7_r <= bad6_r;   r7_r <= r7_nxt;   k2_7_r <= k2_6_r;
    bad8_r <= bad7_r;   r8_r <= r7_r;     r2_8_r <= r2_8_nxt; k2_8_r <= k2_7_r;
  end

  assign red = '{valid: v8_r, bad: bad8_r, k2: k2_8_r, r: r8_r, r2: r2_8_r};

endmodule

// ----- rtl/core/fss_poly.sv -----
// ----------------------------------------------------------------------------
// fss_poly
// Seven-stage evaluation of the odd (sine) and even (cosine) polynomials
// of the reduced argument, at most one float operation per stage per side.
// ----------------------------------------------------------------------------
module fss_poly
  import fss_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  fss_red_t  red,
  output fss_poly_t poly
);

  logic [6:0]  v_r;
  logic        bad9_r, bad10_r, bad11_r, bad12_r, bad13_r, bad14_r, bad15_r;
  logic [1:0]  k9_r, k10_r, k11_r, k12_r, k13_r, k14_r, k15_r;
  logic [31:0] r9_r, r10_r, r11_r, r12_r, r13_r, r14_r;
  logic [31:0] q9_r, q10_r, q11_r, q12_r;
  logic [31:0] sa9_r, sa10_r, sa11_r, sa12_r, sa13_r, sa14_r, s15_r;
  logic [31:0] ca9_r, ca10_r, ca11_r, ca12_r, ca13_r, c14_r, c15_r;

  logic [31:0] sa9_nxt, sa10_nxt, sa11_nxt, sa12_nxt, sa13_nxt, sa14_nxt, s15_nxt;
  logic [31:0] ca9_nxt, ca10_nxt, ca11_nxt, ca12_nxt, ca13_nxt, c14_nxt;

  always_comb begin
    sa9_nxt  = f_mul(red.r2, SIN_C7);
    ca9_nxt  = f_mul(red.r2, COS_C6);
    sa10_nxt = f_sub(SIN_C5, sa9_r);
    ca10_nxt = f_sub(COS_C4, ca9_r);
    sa11_nxt = f_mul(q10_r, sa10_r);
    ca11_nxt = f_mul(q10_r, ca10_r);
    sa12_nxt = f_sub(SIN_C3, sa11_r);
    ca12_nxt = f_sub(F_HALF, ca11_r);
    sa13_nxt = f_mul(q12_r, sa12_r);
    ca13_nxt = f_mul(q12_r, ca12_r);
    sa14_nxt = f_sub(F_ONE, sa13_r);
    c14_nxt  = f_sub(F_ONE, ca13_r);
    s15_nxt  = f_mul(r14_r, sa14_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[5:0], red.valid};
    end
  end

  always_ff @(posedge clk) begin
    bad9_r  <= red.bad; k9_r  <= red.k2; r9_r  <= red.r;  q9_r  <= red.r2;
    sa9_r   <= sa9_nxt; ca9_r <= ca9_nxt;
    bad10_r <= bad9_r;  k10_r <= k9_r;   r10_r <= r9_r;   q10_r <= q9_r;
    sa10_r  <= sa10_nxt; ca10_r <= ca10_nxt;
    bad11_r <= bad10_r; k11_r <= k10_r;  r11_r <= r10_r;  q11_r <= q10_r;
    sa11_r  <= sa11_nxt; ca11_r <= ca11_nxt;
    bad12_r <= bad11_r; k12_r <= k11_r;  r12_r <= r11_r;  q12_r <= q11_r;
    sa12_r  <= sa12_nxt; ca12_r <= ca12_nxt;
    bad13_r <= bad12_r; k13_r <= k12_r;  r13_r <= r12_r;
    sa13_r  <= sa13_nxt; ca13_r <= ca13_nxt;
    bad14_r <= bad13_r; k14_r <= k13_r;  r14_r <= r13_r;
    sa14_r  <= sa14_nxt; c14_r <= c14_nxt;
    bad15_r <= bad14_r; k15_r <= k14_r;
    s15_r   <= s15_nxt; c15_r <= c14_r;
  end

  assign poly = '{valid: v_r[6], bad: bad15_r, k2: k15_r, s: s15_r, c: c15_r};

endmodule

// ----- rtl/core/float_sine_cosine_polynomial.sv -----
// ----------------------------------------------------------------------------
// float_sine_cosine_polynomial
// Float32 sine or cosine by quadrant reduction and Taylor polynomials.
// ----------------------------------------------------------------------------
// The result passes through 16 register stages: the reduction pipe, the
// polynomial pipe and the output register.
// Throughput: one request per cycle; busy is always low, at most one float
// operation per pipeline stage on each path sets the clock.
// Reset clears only the valid bits of the pipeline; results are not stalled.
module float_sine_cosine_polynomial
  import fss_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  fss_in_t  in_data,
  output logic     out_valid,
  output fss_out_t out_data
);

  logic      accept;
  fss_red_t  red;
  fss_poly_t poly;
  logic      out_valid_r;
  fss_out_t  out_data_r, out_data_nxt;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  fss_reduce u_reduce (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (accept),
    .in_data  (in_data),
    .red      (red)
  );

  fss_poly u_poly (
    .clk   (clk),
    .rst_n (rst_n),
    .red   (red),
    .poly  (poly)
  );

  always_comb begin
    out_data_nxt.range_error = poly.bad;
    case (fss_quad_t'(poly.k2))
      QUAD_SIN:     out_data_nxt.y_bits = poly.s;
      QUAD_COS:     out_data_nxt.y_bits = poly.c;
      QUAD_NEG_SIN: out_data_nxt.y_bits = f_neg(poly.s);
      default:      out_data_nxt.y_bits = f_neg(poly.c);
    endcase
    if (poly.bad) out_data_nxt.y_bits = QNAN_BITS;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= poly.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##16 out_valid)
    else $error("request did not produce a result after 16 cycles");

  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, 16))
    else $error("result without a matching request");

  a_err_nan: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.range_error) |-> (out_data.y_bits == QNAN_BITS))
    else $error("range error without quiet NaN");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives float32 sine and cosine requests into float_sine_cosine_polynomial
// and checks every result bit for bit against a typed-in value or a float32
// software model of the same operation sequence, with or without random gaps.
// ----------------------------------------------------------------------------
module testbench;
  import fss_pkg::*;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  fss_in_t  in_data;
  logic     out_valid;
  fss_out_t out_data;

  // Typed-in result that travels alongside the request, if the row has one.
  typedef struct packed {
    logic     known;
    fss_out_t res;
  } note_t;

  typedef struct packed {
    logic        op;
    logic [31:0] x;
    logic        known;
    logic [31:0] y;
    logic        err;
  } row_t;

  note_t    req_note;
  fss_out_t sincos_q[$];
  int       errors = 0;

  float_sine_cosine_polynomial dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  // Rounds sign * mag * 2^x to the nearest float32, ties to even.
  function automatic logic [31:0] round_f32(input logic sgn, input logic [127:0] mag,
                                            input int x);
    int           p, q, s;
    logic [127:0] mant;
    logic         g, st;
    logic [8:0]   bexp;
    p = -1;
    for (int i = 0; i < 128; i++) if (mag[i]) p = i;
    if (p < 0) return {sgn, 31'd0};
    q = p + x - 23;
    if (q < -149) q = -149;
    s = q - x;
    if (s <= 0) begin
      mant = mag << (-s); g = 1'b0; st = 1'b0;
    end else if (s > 128) begin
      mant = '0; g = 1'b0; st = 1'b1;
    end else begin
      mant = mag >> s;
      g    = mag[s-1];
      st   = (mag & ((128'd1 << (s - 1)) - 128'd1)) != '0;
    end
    if (g && (st || mant[0])) mant = mant + 128'd1;
    if (mant[24]) begin
      mant = mant >> 1; q = q + 1;
    end
    if (!mant[23]) return {sgn, 8'd0, mant[22:0]};
    bexp = 9'(q + 150);
    if (q + 150 >= 255) return {sgn, 8'hFF, 23'd0};
    return {sgn, bexp[7:0], mant[22:0]};
  endfunction

  function automatic logic [23:0] sig_of(input logic [31:0] a);
    return {a[30:23] != 8'd0, a[22:0]};
  endfunction

  function automatic int exp_of(input logic [31:0] a);
    return ((a[30:23] == 8'd0) ? 1 : int'(a[30:23])) - 150;
  endfunction

  function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
    logic sgn;
    sgn = a[31] ^ b[31];
    if (a[30:0] == '0 || b[30:0] == '0) return {sgn, 31'd0};
    return round_f32(sgn, 128'(sig_of(a)) * 128'(sig_of(b)), exp_of(a) + exp_of(b));
  endfunction

  function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
    logic [31:0]  big, lit;
    logic [127:0] mb, ml, mag;
    int           d, x;
    logic         sgn;
    if (a[30:0] == '0 && b[30:0] == '0) return {a[31] & b[31], 31'd0};
    if (exp_of(a) >= exp_of(b)) begin
      big = a; lit = b;
    end else begin
      big = b; lit = a;
    end
    d = exp_of(big) - exp_of(lit);
    if (d <= 60) begin
      mb = 128'(sig_of(big)) << d; ml = 128'(sig_of(lit)); x = exp_of(lit);
    end else begin
      // The small operand only decides the sticky bit here.
      mb = 128'(sig_of(big)) << 62; ml = 128'(sig_of(lit) != '0); x = exp_of(big) - 62;
    end
    if (big[31] == lit[31]) begin
      mag = mb + ml; sgn = big[31];
    end else if (mb >= ml) begin
      mag = mb - ml; sgn = big[31];
    end else begin
      mag = ml - mb; sgn = lit[31];
    end
    if (mag == '0) return 32'd0;
    return round_f32(sgn, mag, x);
  endfunction

  function automatic logic [31:0] fp_sub(input logic [31:0] a, input logic [31:0] b);
    return fp_add(a, {~b[31], b[30:0]});
  endfunction

  function automatic fss_out_t sincos_predict(input fss_in_t req);
    logic [31:0] a, fk, t, kf, r, r2, s, c, p;
    logic [63:0] kmag;
    logic [31:0] k;
    int          e;
    fss_out_t    res;
    a   = req.x_bits;
    res = '{y_bits: QNAN_BITS, range_error: 1'b1};
    if (a[30:23] == 8'hFF) return res;
    if (req.op == OP_COS) a = fp_add(a, HALF_PI);
    if (a[30:23] == 8'hFF) return res;
    fk = fp_mul(a, INV_HALF_PI);
    if (fk[30:23] >= EXP_2P31) return res;
    // Negative zero counts as non-negative, as in a float compare.
    t = (!fk[31] || fk[30:0] == '0) ? fp_add(fk, F_HALF) : fp_sub(fk, F_HALF);
    e = exp_of(t);
    kmag = (e >= 0) ? (64'(sig_of(t)) << e) : (64'(sig_of(t)) >> (-e));
    k  = t[31] ? -kmag[31:0] : kmag[31:0];
    kf = round_f32(t[31] && kmag != '0, 128'(kmag), 0);
    r  = fp_sub(fp_sub(a, fp_mul(kf, CW_HI)), fp_mul(kf, CW_LO));
    r2 = fp_mul(r, r);
    s  = fp_mul(r, fp_sub(F_ONE, fp_mul(r2, fp_sub(SIN_C3,
           fp_mul(r2, fp_sub(SIN_C5, fp_mul(r2, SIN_C7)))))));
    c  = fp_sub(F_ONE, fp_mul(r2, fp_sub(F_HALF,
           fp_mul(r2, fp_sub(COS_C4, fp_mul(r2, COS_C6))))));
    case (fss_quad_t'(k[1:0]))
      QUAD_SIN:     p = s;
      QUAD_COS:     p = c;
      QUAD_NEG_SIN: p = {~s[31], s[30:0]};
      default:      p = {~c[31], c[30:0]};
    endcase
    res.y_bits      = p;
    res.range_error = 1'b0;
    return res;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("%0t mismatch %s: got %h, expected %h", $time, what, got, want);
    errors++;
  endtask

  // Queue the expected result at the accepting edge; compare at strobe end.
  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      sincos_q.push_back(req_note.known ? req_note.res : sincos_predict(in_data));
    end
    if (rst_n && out_valid) begin
      if (sincos_q.size() == 0) begin
        report("unexpected result", out_data.y_bits, 32'd0);
      end else begin
        fss_out_t want;
        want = sincos_q.pop_front();
        if (out_data.y_bits !== want.y_bits) report("y_bits", out_data.y_bits, want.y_bits);
        if (out_data.range_error !== want.range_error)
          report("range_error", 32'(out_data.range_error), 32'(want.range_error));
      end
    end
  end

  task automatic send(input fss_in_t req, input note_t note, input int idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start    <= 1'b1;
    in_data  <= req;
    req_note <= note;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // The first edge lets the last request reach the queue before it is polled.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sincos_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] random_arg();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: v[30:23] = 8'($urandom_range(100, 135));
      6:                v[30:23] = 8'($urandom_range(0, 99));
      7:                v[30:23] = 8'($urandom_range(136, 160));
      8:                ;
      default: begin
        case ($urandom_range(0, 2))
          0:       v[30:0] = 31'd0;
          1:       v[30:23] = 8'hFF;
          default: v[30:0] = {8'hFF, 23'd0};
        endcase
      end
    endcase
    return v;
  endfunction

  row_t dir_rows[] = '{
    '{1'b0, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
    '{1'b0, 32'h8000_0000, 1'b1, 32'h8000_0000, 1'b0},
    '{1'b0, 32'h7FC0_0000, 1'b1, QNAN_BITS,     1'b1},
    '{1'b1, 32'h7F80_0001, 1'b1, QNAN_BITS,     1'b1},
    '{1'b0, 32'h7F80_0000, 1'b1, QNAN_BITS,     1'b1},
    '{1'b1, 32'hFF80_0000, 1'b1, QNAN_BITS,     1'b1},
    '{1'b0, 32'h5015_02F9, 1'b1, QNAN_BITS,     1'b1},
    '{1'b1, 32'hD015_02F9, 1'b1, QNAN_BITS,     1'b1},
    '{1'b0, 32'h7F7F_FFFF, 1'b1, QNAN_BITS,     1'b1},
    '{1'b1, 32'hFF7F_FFFF, 1'b1, QNAN_BITS,     1'b1},
    '{1'b1, 32'h0000_0000, 1'b0, 32'd0, 1'b0},
    '{1'b0, 32'h0000_0001, 1'b0, 32'd0, 1'b0},
    '{1'b0, 32'h8000_0001, 1'b0, 32'd0, 1'b0},
    '{1'b1, 32'h807F_FFFF, 1'b0, 32'd0, 1'b0},
    '{1'b0, 32'h0080_0000, 1'b0, 32'd0, 1'b0},
    '{1'b0, 32'h3FC9_0FDB, 1'b0, 32'd0, 1'b0},
    '{1'b1, 32'h4049_0FDB, 1'b0, 32'd0, 1'b0},
    '{1'b1, 32'h3F80_0000, 1'b0, 32'd0, 1'b0},
    '{1'b0, 32'hBF80_0000, 1'b0, 32'd0, 1'b0},
    '{1'b0, 32'h4F48_0000, 1'b0, 32'd0, 1'b0},
    '{1'b1, 32'hCF48_0000, 1'b0, 32'd0, 1'b0},
    '{1'b0, 32'h4E80_0000, 1'b0, 32'd0, 1'b0},
    '{1'b1, 32'h4AFF_FFFF, 1'b0, 32'd0, 1'b0}
  };

  initial begin
    int idle_pct;
    int n_items;
    int waited;
    start    <= 1'b0;
    in_data  <= '0;
    req_note <= '0;
    rst_n    <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send('{op: dir_rows[i].op, x_bits: dir_rows[i].x},
           '{known: dir_rows[i].known,
             res: '{y_bits: dir_rows[i].y, range_error: dir_rows[i].err}}, 0);
    end
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 38 : (ph == 1) ? 61 : 0;
      n_items  = (ph == 2) ? 610 : 620;
      for (int n = 0; n < n_items; n++) begin
        send('{op: 1'($urandom), x_bits: random_arg()}, '0, idle_pct);
      end
      // Hold off new requests until the pipeline has emptied.
      drain();
    end

    start  <= 1'b0;
    waited = 0;
    while (sincos_q.size() != 0 && waited < 1000) begin
      @(posedge clk);
      waited++;
    end
    repeat (40) @(posedge clk);
    if (errors == 0 && sincos_q.size() == 0) begin
      $display("PASS float_sine_cosine_polynomial");
    end else begin
      $display("FAIL float_sine_cosine_polynomial");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL float_sine_cosine_polynomial");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/fss_pkg.sv
rtl/core/fss_reduce.sv
rtl/core/fss_poly.sv
rtl/core/float_sine_cosine_polynomial.sv
tb/testbench.sv
